@@ hw/rtl/vpc_pkg.sv @@
// Shared types, codes and the outcode function of the view pyramid polygon clipper.
package vpc_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic signed [31:0] light_level;
        logic               has_tex;
        logic               has_light;
        logic               last_vertex;
    } vtx_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_u;
        logic signed [31:0] out_v;
        logic signed [31:0] out_light;
        logic [4:0]         out_codes;
        logic               out_has_tex;
        logic               out_has_light;
        logic               rejected;
        logic               overflowed;
        logic               last_out;
    } res_t;

    // Stored vertex: flags hold the five outcode bits, then texture and light.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] light;
        logic [6:0]         flags;
    } vert_t;

    localparam int unsigned FLAG_TEX = 5;
    localparam int unsigned FLAG_LIT = 6;
    localparam logic [4:0]  CODES_ALL = 5'h1f;

    localparam logic [1:0] PL_LEFT   = 2'd0;
    localparam logic [1:0] PL_RIGHT  = 2'd1;
    localparam logic [1:0] PL_BOTTOM = 2'd2;
    localparam logic [1:0] PL_TOP    = 2'd3;

    localparam logic [1:0] WSEL_IN    = 2'd0;
    localparam logic [1:0] WSEL_COPY  = 2'd1;
    localparam logic [1:0] WSEL_ISECT = 2'd2;

    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       ld_on;
        logic       ld_off;
        logic       isect_start;
        logic [1:0] plane;
        logic       out_load;
        logic       out_rej;
        logic       out_ovf;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic       isect_done;
        logic [4:0] in_codes;
        logic [6:0] rd_flags;
        logic [4:0] isect_codes;
    } stat_t;

    function automatic logic [4:0] encode(input logic signed [31:0] x,
                                          input logic signed [31:0] y,
                                          input logic signed [31:0] z);
        logic signed [33:0] xe;
        logic signed [33:0] ye;
        logic signed [33:0] ze;
        logic signed [33:0] xpz;
        logic signed [33:0] zmx;
        logic signed [33:0] ypz;
        logic signed [33:0] zmy;
        xe  = {{2{x[31]}}, x};
        ye  = {{2{y[31]}}, y};
        ze  = {{2{z[31]}}, z};
        xpz = xe + ze;
        zmx = ze - xe;
        ypz = ye + ze;
        zmy = ze - ye;
        return {z[31], zmy[33], ypz[33], zmx[33], xpz[33]};
    endfunction

endpackage

@@ hw/rtl/view_pyramid_polygon_clipper.sv @@
// Top level of the view pyramid polygon clipper: controller plus datapath.
//
// Vertices arrive one request per cycle on the vtx channel while vtx_stall is
// low and are written to a two-bank vertex memory with outcodes (left x<-z,
// right x>z, bottom y<-z, top y>z, behind z<0). The request carrying
// last_vertex starts clipping: the polygon is passed, bank to bank, through
// each of the left, right, bottom and top planes it crosses, and every edge
// that leaves the plane yields an intersection point whose position, texture
// and light are interpolated by kn/kd. The surviving vertices then leave on
// the res channel, last_out marking the final one; a polygon wholly outside
// one plane yields a single request with rejected set. Vertices beyond
// MAX_VERTS, on input or in a pass, are dropped and overflowed is raised on
// every result of that polygon. Behind is flagged but never clipped. A pass
// is paced by the single-read-port vertex memory and the radix-2 divider (one
// quotient bit per cycle) feeding a shared multiplier over five fields; each
// result is held until the receiver accepts it before the next is read.
// No new vertex is taken until the last result of the previous polygon has
// been accepted.
module view_pyramid_polygon_clipper
    import vpc_pkg::*;
#(
    parameter int MAX_VERTS = 64,
    parameter int FRAC_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic vtx_valid,
    output logic vtx_stall,
    input  vtx_t vtx,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam int AW = $clog2(2 * MAX_VERTS);

    cmd_t          cmd;
    stat_t         stat;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    // Sequence loading, plane passes and result handout.
    vpc_ctrl #(
        .MAX_VERTS (MAX_VERTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_last  (vtx.last_vertex),
        .vtx_stall (vtx_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .stat      (stat),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr)
    );

    // Hold the vertex banks, compute intersections and drive the result payload.
    vpc_datapath #(
        .MAX_VERTS (MAX_VERTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .vtx     (vtx),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .stat    (stat),
        .res     (res)
    );

endmodule

@@ hw/rtl/vpc_datapath.sv @@
// Vertex memory, intersection unit (serial divider, shared multiplier) and result register.
module vpc_datapath
    import vpc_pkg::*;
#(
    parameter int MAX_VERTS = 64,
    parameter int FRAC_BITS = 16,
    localparam int DEPTH = 2 * MAX_VERTS,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  vtx_t          vtx,
    input  cmd_t          cmd,
    input  logic [AW-1:0] rd_addr,
    input  logic [AW-1:0] wr_addr,
    output stat_t         stat,
    output res_t          res
);

    localparam int DW  = 37;
    localparam int DCW = $clog2(FRAC_BITS + 1);
    localparam int PW  = 34 + FRAC_BITS;

    localparam logic [2:0] IS_IDLE = 3'd0;
    localparam logic [2:0] IS_KN   = 3'd1;
    localparam logic [2:0] IS_KD   = 3'd2;
    localparam logic [2:0] IS_DIV  = 3'd3;
    localparam logic [2:0] IS_LERP = 3'd4;
    localparam logic [2:0] IS_DONE = 3'd5;

    localparam logic [2:0] FLD_X     = 3'd0;
    localparam logic [2:0] FLD_Y     = 3'd1;
    localparam logic [2:0] FLD_U     = 3'd2;
    localparam logic [2:0] FLD_V     = 3'd3;
    localparam logic [2:0] FLD_LIGHT = 3'd4;
    localparam logic [2:0] LERP_LAST = 3'd7;

    vert_t mem [DEPTH];
    vert_t rd_data_reg;
    vert_t on_reg;
    vert_t off_reg;
    vert_t in_word;
    vert_t isect_word;
    vert_t wr_data;
    res_t  res_reg;
    res_t  res_next;

    logic [2:0]            phase_reg;
    logic [1:0]            plane_reg;
    logic signed [33:0]    kn_reg;
    logic signed [33:0]    bz_reg;
    logic [DW-1:0]         rem_reg;
    logic [DW-1:0]         dvs_reg;
    logic [FRAC_BITS-1:0]  quo_reg;
    logic [DCW-1:0]        div_cnt_reg;
    logic [2:0]            idx_reg;
    logic signed [32:0]    diff_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [31:0]    lerp_reg [5];
    logic signed [31:0]    nz_reg;

    logic [4:0]            in_codes;
    logic [4:0]            isect_codes;
    logic                  use_x;
    logic                  negate;
    logic signed [33:0]    a_on;
    logic signed [33:0]    b_off;
    logic signed [DW-1:0]  kn_ext;
    logic signed [DW-1:0]  bz_ext;
    logic [DW-1:0]         rem_shift;
    logic [2:0]            idx_m1;
    logic [2:0]            idx_m2;
    logic signed [31:0]    z_sel;
    logic signed [31:0]    off_fld;
    logic signed [31:0]    on_fld;
    logic signed [31:0]    on_fld_m2;

    function automatic logic signed [31:0] pick(input vert_t v, input logic [2:0] f);
        logic signed [31:0] r;
        unique case (f)
            FLD_X:     r = v.x;
            FLD_Y:     r = v.y;
            FLD_U:     r = v.u;
            FLD_V:     r = v.v;
            FLD_LIGHT: r = v.light;
            default:   r = v.x;
        endcase
        return r;
    endfunction

    // Incoming vertex: drop absent texture and light.
    always_comb
    begin
        in_codes      = encode(vtx.pos_x, vtx.pos_y, vtx.pos_z);
        in_word.x     = vtx.pos_x;
        in_word.y     = vtx.pos_y;
        in_word.z     = vtx.pos_z;
        in_word.u     = vtx.has_tex ? vtx.tex_u : '0;
        in_word.v     = vtx.has_tex ? vtx.tex_v : '0;
        in_word.light = vtx.has_light ? vtx.light_level : '0;
        in_word.flags = {vtx.has_light, vtx.has_tex, in_codes};
    end

    always_comb
    begin
        isect_codes      = encode(lerp_reg[0], lerp_reg[1], nz_reg);
        isect_word.x     = lerp_reg[0];
        isect_word.y     = lerp_reg[1];
        isect_word.z     = nz_reg;
        isect_word.u     = on_reg.flags[FLAG_TEX] ? lerp_reg[2] : '0;
        isect_word.v     = on_reg.flags[FLAG_TEX] ? lerp_reg[3] : '0;
        isect_word.light = on_reg.flags[FLAG_LIT] ? lerp_reg[4] : '0;
        isect_word.flags = {on_reg.flags[FLAG_LIT], on_reg.flags[FLAG_TEX], isect_codes};
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            WSEL_IN:    wr_data = in_word;
            WSEL_COPY:  wr_data = rd_data_reg;
            WSEL_ISECT: wr_data = isect_word;
            default:    wr_data = in_word;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_on)
        begin
            on_reg <= rd_data_reg;
        end
        if (cmd.ld_off)
        begin
            off_reg <= rd_data_reg;
        end
    end

    // Plane distances of both edge ends.
    always_comb
    begin
        use_x     = (plane_reg == PL_LEFT) || (plane_reg == PL_RIGHT);
        negate    = (plane_reg == PL_LEFT) || (plane_reg == PL_BOTTOM);
        a_on      = use_x ? {{2{on_reg.x[31]}}, on_reg.x} : {{2{on_reg.y[31]}}, on_reg.y};
        b_off     = use_x ? {{2{off_reg.x[31]}}, off_reg.x} : {{2{off_reg.y[31]}}, off_reg.y};
        if (negate)
        begin
            a_on  = -a_on;
            b_off = -b_off;
        end
        kn_ext    = {{(DW-34){kn_reg[33]}}, kn_reg};
        bz_ext    = {{(DW-34){bz_reg[33]}}, bz_reg};
        rem_shift = {rem_reg[DW-2:0], 1'b0};
        idx_m1    = idx_reg - 3'd1;
        idx_m2    = idx_reg - 3'd2;
        z_sel     = use_x ? lerp_reg[0] : lerp_reg[1];
        off_fld   = pick(off_reg, idx_reg);
        on_fld    = pick(on_reg, idx_reg);
        on_fld_m2 = pick(on_reg, idx_m2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= IS_IDLE;
            div_cnt_reg <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            unique case (phase_reg)
                IS_IDLE:
                begin
                    if (cmd.isect_start)
                    begin
                        phase_reg <= IS_KN;
                    end
                end
                IS_KN:
                begin
                    phase_reg <= IS_KD;
                end
                IS_KD:
                begin
                    div_cnt_reg <= '0;
                    phase_reg   <= IS_DIV;
                end
                IS_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DCW'(FRAC_BITS - 1))
                    begin
                        idx_reg   <= '0;
                        phase_reg <= IS_LERP;
                    end
                end
                IS_LERP:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == LERP_LAST)
                    begin
                        phase_reg <= IS_DONE;
                    end
                end
                IS_DONE:
                begin
                    phase_reg <= IS_IDLE;
                end
                default:
                begin
                    phase_reg <= IS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((phase_reg == IS_IDLE) && cmd.isect_start)
        begin
            plane_reg <= cmd.plane;
        end
        if (phase_reg == IS_KN)
        begin
            kn_reg <= a_on - {{2{on_reg.z[31]}}, on_reg.z};
            bz_reg <= b_off - {{2{off_reg.z[31]}}, off_reg.z};
        end
        if (phase_reg == IS_KD)
        begin
            // the inside end gives kn <= 0 and kd < 0: divide magnitudes
            rem_reg <= DW'(-kn_ext);
            dvs_reg <= DW'(bz_ext - kn_ext);
            quo_reg <= '0;
        end
        if (phase_reg == IS_DIV)
        begin
            if (rem_shift >= dvs_reg)
            begin
                rem_reg <= rem_shift - dvs_reg;
                quo_reg <= {quo_reg[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[FRAC_BITS-2:0], 1'b0};
            end
        end
        if (phase_reg == IS_LERP)
        begin
            if (idx_reg <= FLD_LIGHT)
            begin
                diff_reg <= {off_fld[31], off_fld} - {on_fld[31], on_fld};
            end
            if ((idx_reg >= 3'd1) && (idx_m1 <= FLD_LIGHT))
            begin
                prod_reg <= diff_reg * signed'({1'b0, quo_reg});
            end
            if ((idx_reg >= 3'd2) && (idx_m2 <= FLD_LIGHT))
            begin
                lerp_reg[idx_m2] <= on_fld_m2 + prod_reg[FRAC_BITS+31:FRAC_BITS];
            end
            if (idx_reg == LERP_LAST)
            begin
                nz_reg <= negate ? -z_sel : z_sel;
            end
        end
    end

    always_comb
    begin
        res_next = res_reg;
        if (cmd.out_load)
        begin
            if (cmd.out_rej)
            begin
                res_next          = '0;
                res_next.rejected = 1'b1;
            end
            else
            begin
                res_next.out_x         = rd_data_reg.x;
                res_next.out_y         = rd_data_reg.y;
                res_next.out_z         = rd_data_reg.z;
                res_next.out_u         = rd_data_reg.u;
                res_next.out_v         = rd_data_reg.v;
                res_next.out_light     = rd_data_reg.light;
                res_next.out_codes     = rd_data_reg.flags[4:0];
                res_next.out_has_tex   = rd_data_reg.flags[FLAG_TEX];
                res_next.out_has_light = rd_data_reg.flags[FLAG_LIT];
                res_next.rejected      = 1'b0;
            end
            res_next.overflowed = cmd.out_ovf;
            res_next.last_out   = cmd.out_last;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_comb
    begin
        stat.isect_done  = (phase_reg == IS_DONE);
        stat.in_codes    = in_codes;
        stat.rd_flags    = rd_data_reg.flags;
        stat.isect_codes = isect_codes;
    end

    assign res = res_reg;

endmodule

@@ hw/rtl/vpc_ctrl.sv @@
// Controller: vertex loading, plane passes over the two banks, and result sequencing.
module vpc_ctrl
    import vpc_pkg::*;
#(
    parameter int MAX_VERTS = 64,
    localparam int AW = $clog2(2 * MAX_VERTS),
    localparam int IW = $clog2(MAX_VERTS),
    localparam int CW = $clog2(MAX_VERTS + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          vtx_valid,
    input  logic          vtx_last,
    output logic          vtx_stall,
    output logic          res_valid,
    input  logic          res_stall,
    input  stat_t         stat,
    output cmd_t          cmd,
    output logic [AW-1:0] rd_addr,
    output logic [AW-1:0] wr_addr
);

    localparam logic [3:0] S_LOAD      = 4'd0;
    localparam logic [3:0] S_START     = 4'd1;
    localparam logic [3:0] S_PLANE     = 4'd2;
    localparam logic [3:0] S_CUR       = 4'd3;
    localparam logic [3:0] S_CUR_W     = 4'd4;
    localparam logic [3:0] S_PRV_W     = 4'd5;
    localparam logic [3:0] S_ISECT1    = 4'd6;
    localparam logic [3:0] S_NXT_W     = 4'd7;
    localparam logic [3:0] S_ISECT2    = 4'd8;
    localparam logic [3:0] S_NEXT      = 4'd9;
    localparam logic [3:0] S_CHECK     = 4'd10;
    localparam logic [3:0] S_EMIT_RD   = 4'd11;
    localparam logic [3:0] S_EMIT_LD   = 4'd12;
    localparam logic [3:0] S_EMIT_WAIT = 4'd13;
    localparam logic [3:0] S_REJ_LD    = 4'd14;
    localparam logic [3:0] S_REJ_WAIT  = 4'd15;

    localparam logic [2:0] PLANES_DONE = 3'd4;

    logic [3:0]    state_reg,  state_next;
    logic [CW-1:0] vcount_reg, vcount_next;
    logic [CW-1:0] n_reg,      n_next;
    logic [CW-1:0] cnt_reg,    cnt_next;
    logic [CW-1:0] i_reg,      i_next;
    logic [CW-1:0] k_reg,      k_next;
    logic [IW-1:0] prv_reg,    prv_next;
    logic [4:0]    or_reg,     or_next;
    logic [4:0]    and_reg,    and_next;
    logic          bank_reg,   bank_next;
    logic          ovf_reg,    ovf_next;
    logic [2:0]    plane_reg,  plane_next;
    logic          res_valid_reg, res_valid_next;

    logic [IW-1:0] cur_idx;
    logic [IW-1:0] nxt_idx;
    logic          cnt_full;
    logic          k_last;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x, input logic [CW-1:0] n);
        logic [CW-1:0] t;
        t = CW'(x) + 1'b1;
        return (t == n) ? '0 : IW'(t);
    endfunction

    function automatic logic [AW-1:0] addr(input logic bank, input logic [IW-1:0] idx);
        return bank ? AW'(MAX_VERTS) + AW'(idx) : AW'(idx);
    endfunction

    assign cur_idx   = wrap_inc(prv_reg, n_reg);
    assign nxt_idx   = wrap_inc(cur_idx, n_reg);
    assign cnt_full  = (cnt_reg >= CW'(MAX_VERTS));
    assign k_last    = ((k_reg + 1'b1) == n_reg);
    assign vtx_stall = (state_reg != S_LOAD);
    assign res_valid = res_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        vcount_next    = vcount_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        prv_next       = prv_reg;
        or_next        = or_reg;
        and_next       = and_reg;
        bank_next      = bank_reg;
        ovf_next       = ovf_reg;
        plane_next     = plane_reg;
        res_valid_next = res_valid_reg;
        cmd            = '0;
        cmd.plane      = plane_reg[1:0];
        cmd.out_ovf    = ovf_reg;
        rd_addr        = '0;
        wr_addr        = addr(~bank_reg, IW'(cnt_reg));

        unique case (state_reg)
            S_LOAD:
            begin
                if (vtx_valid)
                begin
                    if (vcount_reg < CW'(MAX_VERTS))
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = WSEL_IN;
                        wr_addr     = AW'(vcount_reg);
                        or_next     = or_reg | stat.in_codes;
                        and_next    = and_reg & stat.in_codes;
                        vcount_next = vcount_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (vtx_last)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                n_next     = vcount_reg;
                plane_next = '0;
                if ((vcount_reg == '0) || (and_reg != '0))
                begin
                    state_next = S_REJ_LD;
                end
                else
                begin
                    state_next = S_PLANE;
                end
            end
            S_PLANE:
            begin
                if (plane_reg == PLANES_DONE)
                begin
                    k_next     = '0;
                    state_next = S_EMIT_RD;
                end
                else if (or_reg[plane_reg])
                begin
                    cnt_next   = '0;
                    i_next     = CW'(1);
                    prv_next   = '0;
                    or_next    = '0;
                    and_next   = CODES_ALL;
                    state_next = S_CUR;
                end
                else
                begin
                    plane_next = plane_reg + 1'b1;
                end
            end
            S_CUR:
            begin
                cmd.rd_en  = 1'b1;
                rd_addr    = addr(bank_reg, cur_idx);
                state_next = S_CUR_W;
            end
            S_CUR_W:
            begin
                cmd.ld_off = 1'b1;
                if (stat.rd_flags[plane_reg])
                begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = addr(bank_reg, prv_reg);
                    state_next = S_PRV_W;
                end
                else
                begin
                    // inside: copy through
                    if (cnt_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = WSEL_COPY;
                        or_next    = or_reg | stat.rd_flags[4:0];
                        and_next   = and_reg & stat.rd_flags[4:0];
                        cnt_next   = cnt_reg + 1'b1;
                    end
                    state_next = S_NEXT;
                end
            end
            S_PRV_W:
            begin
                if (!stat.rd_flags[plane_reg])
                begin
                    cmd.ld_on       = 1'b1;
                    cmd.isect_start = 1'b1;
                    state_next      = S_ISECT1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = addr(bank_reg, nxt_idx);
                    state_next = S_NXT_W;
                end
            end
            S_ISECT1, S_ISECT2:
            begin
                if (stat.isect_done)
                begin
                    if (cnt_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = WSEL_ISECT;
                        or_next    = or_reg | stat.isect_codes;
                        and_next   = and_reg & stat.isect_codes;
                        cnt_next   = cnt_reg + 1'b1;
                    end
                    if (state_reg == S_ISECT1)
                    begin
                        cmd.rd_en  = 1'b1;
                        rd_addr    = addr(bank_reg, nxt_idx);
                        state_next = S_NXT_W;
                    end
                    else
                    begin
                        state_next = S_NEXT;
                    end
                end
            end
            S_NXT_W:
            begin
                if (!stat.rd_flags[plane_reg])
                begin
                    cmd.ld_on       = 1'b1;
                    cmd.isect_start = 1'b1;
                    state_next      = S_ISECT2;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (i_reg == n_reg)
                begin
                    n_next     = cnt_reg;
                    bank_next  = ~bank_reg;
                    state_next = S_CHECK;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    prv_next   = cur_idx;
                    state_next = S_CUR;
                end
            end
            S_CHECK:
            begin
                if ((n_reg == '0) || (and_reg != '0))
                begin
                    state_next = S_REJ_LD;
                end
                else
                begin
                    plane_next = plane_reg + 1'b1;
                    state_next = S_PLANE;
                end
            end
            S_EMIT_RD:
            begin
                cmd.rd_en  = 1'b1;
                rd_addr    = addr(bank_reg, IW'(k_reg));
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = k_last;
                res_valid_next = 1'b1;
                state_next     = S_EMIT_WAIT;
            end
            S_REJ_LD:
            begin
                cmd.out_load   = 1'b1;
                cmd.out_rej    = 1'b1;
                cmd.out_last   = 1'b1;
                res_valid_next = 1'b1;
                state_next     = S_REJ_WAIT;
            end
            S_EMIT_WAIT, S_REJ_WAIT:
            begin
                if (!res_stall)
                begin
                    res_valid_next = 1'b0;
                    if ((state_reg == S_REJ_WAIT) || k_last)
                    begin
                        vcount_next = '0;
                        or_next     = '0;
                        and_next    = CODES_ALL;
                        bank_next   = 1'b0;
                        ovf_next    = 1'b0;
                        state_next  = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            vcount_reg    <= '0;
            n_reg         <= '0;
            cnt_reg       <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            prv_reg       <= '0;
            or_reg        <= '0;
            and_reg       <= CODES_ALL;
            bank_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            plane_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            prv_reg       <= prv_next;
            or_reg        <= or_next;
            and_reg       <= and_next;
            bank_reg      <= bank_next;
            ovf_reg       <= ovf_next;
            plane_reg     <= plane_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

@@ test/view_pyramid_polygon_clipper_checker.sv @@
// Checker for the view pyramid polygon clipper: predicts clipped vertices and compares results.
module view_pyramid_polygon_clipper_checker
    import vpc_pkg::*;
#(
    parameter int MAX_VERTS = 64,
    parameter int FRAC_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic vtx_valid,
    input  logic vtx_stall,
    input  vtx_t vtx,
    input  logic res_valid,
    input  logic res_stall,
    input  res_t res,
    output int   fails,
    output int   pending,
    output int   results_seen
);

    localparam int DEPTH = 2 * MAX_VERTS;

    longint     px [DEPTH];
    longint     py [DEPTH];
    longint     pz [DEPTH];
    longint     pu [DEPTH];
    longint     pv [DEPTH];
    longint     pl [DEPTH];
    logic [6:0] pf [DEPTH];
    int         vcount;
    logic [4:0] or_codes;
    logic [4:0] and_codes;
    int         bank;
    logic       ovf;
    res_t       clipped_q[$];

    function automatic longint wrap32(longint v);
        return longint'($signed(v[31:0]));
    endfunction

    function automatic logic [4:0] outcodes(longint x, longint y, longint z);
        logic [4:0] c;
        c = '0;
        if (x < -z) c[0] = 1'b1;
        if (x > z)  c[1] = 1'b1;
        if (y < -z) c[2] = 1'b1;
        if (y > z)  c[3] = 1'b1;
        if (z < 0)  c[4] = 1'b1;
        return c;
    endfunction

    function automatic longint lerp(longint on_v, longint off_v, longint ratio);
        longint p;
        longint one;
        longint q;
        one = longint'(1) <<< FRAC_BITS;
        p   = (off_v - on_v) * ratio;
        if (p >= 0) q = p / one;
        else        q = -((-p + one - 1) / one);
        return wrap32(on_v + q);
    endfunction

    // Intersection of edge on..off with one plane, written to entry dst.
    task automatic cut(input logic [1:0] plane, input int on, input int off, input int dst);
        longint a, b, kn, kd, ratio, nx, ny, nz;
        logic   tex, lit;
        tex = pf[on][FLAG_TEX];
        lit = pf[on][FLAG_LIT];
        if (plane == PL_LEFT || plane == PL_RIGHT) begin
            a = px[on];
            b = px[off];
        end
        else begin
            a = py[on];
            b = py[off];
        end
        if (plane == PL_LEFT || plane == PL_BOTTOM) begin
            a = -a;
            b = -b;
        end
        kn    = a - pz[on];
        kd    = kn - b + pz[off];
        ratio = (kd != 0) ? (kn * (longint'(1) <<< FRAC_BITS)) / kd : 0;
        nx = lerp(px[on], px[off], ratio);
        ny = lerp(py[on], py[off], ratio);
        nz = (plane == PL_BOTTOM || plane == PL_TOP) ? ny : nx;
        if (plane == PL_LEFT || plane == PL_BOTTOM) nz = -nz;
        nz = wrap32(nz);
        pu[dst] = tex ? lerp(pu[on], pu[off], ratio) : 0;
        pv[dst] = tex ? lerp(pv[on], pv[off], ratio) : 0;
        pl[dst] = lit ? lerp(pl[on], pl[off], ratio) : 0;
        px[dst] = nx;
        py[dst] = ny;
        pz[dst] = nz;
        pf[dst] = {lit, tex, outcodes(nx, ny, nz)};
    endtask

    task automatic plane_pass(input logic [1:0] plane, inout int n);
        int sb, db, cnt, cur, prv, nxt, k, nend;
        int ends[2];
        sb  = bank * MAX_VERTS;
        db  = (bank ^ 1) * MAX_VERTS;
        cnt = 0;
        or_codes  = '0;
        and_codes = CODES_ALL;
        for (int i = 1; i <= n; i++) begin
            cur  = sb + i % n;
            prv  = sb + (i - 1) % n;
            nxt  = sb + (i + 1) % n;
            nend = 0;
            if (pf[cur][plane]) begin
                if (!pf[prv][plane]) begin
                    ends[nend] = prv;
                    nend = nend + 1;
                end
                if (!pf[nxt][plane]) begin
                    ends[nend] = nxt;
                    nend = nend + 1;
                end
                for (k = 0; k < nend; k++) begin
                    if (cnt >= MAX_VERTS) begin
                        ovf = 1'b1;
                        continue;
                    end
                    cut(plane, ends[k], cur, db + cnt);
                    or_codes  |= pf[db + cnt][4:0];
                    and_codes &= pf[db + cnt][4:0];
                    cnt++;
                end
            end
            else begin
                if (cnt >= MAX_VERTS) begin
                    ovf = 1'b1;
                    continue;
                end
                px[db + cnt] = px[cur];
                py[db + cnt] = py[cur];
                pz[db + cnt] = pz[cur];
                pu[db + cnt] = pu[cur];
                pv[db + cnt] = pv[cur];
                pl[db + cnt] = pl[cur];
                pf[db + cnt] = pf[cur];
                or_codes  |= pf[cur][4:0];
                and_codes &= pf[cur][4:0];
                cnt++;
            end
        end
        bank ^= 1;
        n = cnt;
    endtask

    task automatic end_polygon();
        vcount    = 0;
        or_codes  = '0;
        and_codes = CODES_ALL;
        bank      = 0;
        ovf       = 1'b0;
    endtask

    // Store one accepted vertex; on the last one clip and queue the results.
    task automatic take_vertex(input vtx_t v);
        int         d, n, s;
        logic       rej;
        logic [4:0] c;
        res_t       r;
        if (vcount < MAX_VERTS) begin
            d = bank * MAX_VERTS + vcount;
            c = outcodes(v.pos_x, v.pos_y, v.pos_z);
            px[d] = v.pos_x;
            py[d] = v.pos_y;
            pz[d] = v.pos_z;
            pu[d] = v.has_tex ? longint'(v.tex_u) : 0;
            pv[d] = v.has_tex ? longint'(v.tex_v) : 0;
            pl[d] = v.has_light ? longint'(v.light_level) : 0;
            pf[d] = {v.has_light, v.has_tex, c};
            or_codes  |= c;
            and_codes &= c;
            vcount++;
        end
        else begin
            ovf = 1'b1;
        end
        if (!v.last_vertex) return;
        n   = vcount;
        rej = (n == 0 || and_codes != 0);
        for (int p = 0; p < 4 && !rej; p++) begin
            if (or_codes[p]) begin
                plane_pass(2'(p), n);
                rej = (n == 0 || and_codes != 0);
            end
        end
        if (rej) begin
            r = '0;
            r.rejected   = 1'b1;
            r.overflowed = ovf;
            r.last_out   = 1'b1;
            clipped_q.push_back(r);
        end
        else begin
            for (int k = 0; k < n; k++) begin
                s = bank * MAX_VERTS + k;
                r.out_x         = px[s][31:0];
                r.out_y         = py[s][31:0];
                r.out_z         = pz[s][31:0];
                r.out_u         = pu[s][31:0];
                r.out_v         = pv[s][31:0];
                r.out_light     = pl[s][31:0];
                r.out_codes     = pf[s][4:0];
                r.out_has_tex   = pf[s][FLAG_TEX];
                r.out_has_light = pf[s][FLAG_LIT];
                r.rejected      = 1'b0;
                r.overflowed    = ovf;
                r.last_out      = (k + 1 == n);
                clipped_q.push_back(r);
            end
        end
        end_polygon();
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH result %0d %s: got %h, want %h", results_seen, what, got, want);
        fails++;
    endtask

    task automatic compare(input res_t got, input res_t want);
        if (got.out_x !== want.out_x) report("out_x", got.out_x, want.out_x);
        if (got.out_y !== want.out_y) report("out_y", got.out_y, want.out_y);
        if (got.out_z !== want.out_z) report("out_z", got.out_z, want.out_z);
        if (got.out_u !== want.out_u) report("out_u", got.out_u, want.out_u);
        if (got.out_v !== want.out_v) report("out_v", got.out_v, want.out_v);
        if (got.out_light !== want.out_light) report("out_light", got.out_light, want.out_light);
        if (got.out_codes !== want.out_codes)
            report("out_codes", 32'(got.out_codes), 32'(want.out_codes));
        if (got.out_has_tex !== want.out_has_tex)
            report("out_has_tex", 32'(got.out_has_tex), 32'(want.out_has_tex));
        if (got.out_has_light !== want.out_has_light)
            report("out_has_light", 32'(got.out_has_light), 32'(want.out_has_light));
        if (got.rejected !== want.rejected)
            report("rejected", 32'(got.rejected), 32'(want.rejected));
        if (got.overflowed !== want.overflowed)
            report("overflowed", 32'(got.overflowed), 32'(want.overflowed));
        if (got.last_out !== want.last_out)
            report("last_out", 32'(got.last_out), 32'(want.last_out));
    endtask

    initial
    begin
        fails        = 0;
        pending      = 0;
        results_seen = 0;
        end_polygon();
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (vtx_valid && !vtx_stall) take_vertex(vtx);
            if (res_valid && !res_stall) begin
                if (clipped_q.size() == 0) begin
                    report("unexpected request", 32'd0, 32'd0);
                end
                else begin
                    compare(res, clipped_q.pop_front());
                end
                results_seen++;
            end
            pending = clipped_q.size();
        end
    end

endmodule

@@ test/view_pyramid_polygon_clipper_tb.sv @@
// Testbench top for the view pyramid polygon clipper: stimulus, stalls and verdict.
module view_pyramid_polygon_clipper_tb;
    import vpc_pkg::*;

    localparam int LIMIT = 600000;

    logic clk;
    logic rst_n;
    logic vtx_valid;
    logic vtx_stall;
    vtx_t vtx;
    logic res_valid;
    logic res_stall;
    res_t res;

    int   fails;
    int   pending;
    int   results_seen;
    int   cycles;
    int   polygons;
    int   sent;
    logic quiet;      // no idling on either side
    logic hold_res;   // long receiver hold-off

    view_pyramid_polygon_clipper i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_stall (vtx_stall),
        .vtx       (vtx),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    view_pyramid_polygon_clipper_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .vtx_valid    (vtx_valid),
        .vtx_stall    (vtx_stall),
        .vtx          (vtx),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .res          (res),
        .fails        (fails),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: give up well beyond the slowest correct run.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("view_pyramid_polygon_clipper_tb failed");
                $finish;
            end
        end
    end

    // Receiver: stall in short random bursts, or hold for a long stretch on request.
    initial
    begin
        int burst;
        res_stall = 1'b0;
        burst     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_res) begin
                res_stall = 1'b1;
            end
            else if (burst > 0) begin
                res_stall = 1'b1;
                burst--;
            end
            else if (!quiet && $urandom_range(0, 5) == 0) begin
                res_stall = 1'b1;
                burst     = $urandom_range(0, 2);
            end
            else begin
                res_stall = 1'b0;
            end
        end
    end

    // Offer one request and hold it until accepted; sometimes idle first for a random burst.
    task automatic send(input vtx_t v);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            vtx_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        vtx_valid = 1'b1;
        vtx       = v;
        do
            @(posedge clk);
        while (vtx_stall);
        @(negedge clk);
        sent++;
    endtask

    function automatic vtx_t mk(int x, int y, int z, logic tex, logic lit, logic last);
        vtx_t v;
        v.pos_x       = x;
        v.pos_y       = y;
        v.pos_z       = z;
        v.tex_u       = $urandom;
        v.tex_v       = $urandom;
        v.light_level = $urandom;
        v.has_tex     = tex;
        v.has_light   = lit;
        v.last_vertex = last;
        return v;
    endfunction

    // Vertex near the view pyramid with positive depth, so clipping does real work.
    function automatic vtx_t near_vertex(logic last, int shift_x);
        int z;
        int x;
        int y;
        z = $urandom_range(32'h0001_0000, 32'h00c8_0000);
        x = int'($urandom_range(0, 4 * z)) - 2 * z + shift_x * z;
        y = int'($urandom_range(0, 4 * z)) - 2 * z;
        return mk(x, y, z, $urandom_range(0, 1), $urandom_range(0, 1), last);
    endfunction

    task automatic send_polygon(input int n, input int kind);
        vtx_t v;
        for (int i = 0; i < n; i++) begin
            if (kind == 0) begin
                v = near_vertex(i == n - 1, 0);
            end
            else if (kind == 1) begin
                // shifted past the right plane: mostly rejected
                v = near_vertex(i == n - 1, 3);
            end
            else begin
                // noise: every bit of every field random
                v = mk($urandom, $urandom, $urandom, $urandom_range(0, 1),
                       $urandom_range(0, 1), i == n - 1);
            end
            send(v);
        end
        polygons++;
    endtask

    initial
    begin
        int one;
        int kind;
        one       = 32'h0001_0000;
        rst_n     = 1'b0;
        vtx_valid = 1'b0;
        vtx       = '0;
        quiet     = 1'b0;
        hold_res  = 1'b0;
        polygons  = 0;
        sent      = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: inside triangle without texture or light.
        send(mk(0, 0, 4 * one, 0, 0, 0));
        send(mk(one, 0, 4 * one, 0, 0, 0));
        send(mk(0, one, 4 * one, 0, 0, 1));
        // Square crossing all four side planes, with texture and light.
        send(mk(-8 * one, -8 * one, 4 * one, 1, 1, 0));
        send(mk(8 * one, -8 * one, 4 * one, 1, 1, 0));
        send(mk(8 * one, 8 * one, 4 * one, 1, 1, 0));
        send(mk(-8 * one, 8 * one, 4 * one, 1, 1, 1));
        // Triangle crossing the left plane only, texture without light.
        send(mk(-6 * one, 0, 2 * one, 1, 0, 0));
        send(mk(one, one, 2 * one, 1, 0, 0));
        send(mk(one, -one, 2 * one, 1, 0, 1));
        // Wholly above the top plane: rejected.
        send(mk(0, 9 * one, one, 1, 1, 0));
        send(mk(one, 9 * one, one, 1, 1, 0));
        send(mk(0, 8 * one, one, 1, 1, 1));
        // Behind the eye: flagged only.
        send(mk(0, 0, -one, 0, 1, 0));
        send(mk(0, 0, 0, 0, 1, 0));
        send(mk(0, 0, one, 0, 1, 1));
        // Extremes of the fields.
        send(mk(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1, 1, 0));
        send(mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1, 1, 0));
        send(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1, 1, 1));
        // Single-vertex polygons, inside then outside.
        send(mk(0, 0, one, 1, 1, 1));
        send(mk(5 * one, 0, one, 1, 1, 1));
        polygons += 8;

        // Zigzag across the right plane with one vertex too many: the dropped
        // last vertex still starts clipping, and the pass outgrows the store.
        for (int i = 0; i < 65; i++)
            send(mk((i % 2) ? 20 * one : 0, i * 1000, 10 * one, 1, 1, i == 64));
        polygons += 1;

        // Random polygons: mostly well formed, some rejected, some noise.
        for (int p = 0; p < 18; p++) begin
            if (p == 4) begin
                // long hold-off on results while vertices keep coming
                fork
                    begin
                        hold_res = 1'b1;
                        repeat (400) @(negedge clk);
                        hold_res = 1'b0;
                    end
                join_none
            end
            if (p == 10) begin
                // pause until every expected result has come
                vtx_valid = 1'b0;
                while (pending != 0) @(negedge clk);
            end
            if (p == 14) quiet = 1'b1;
            kind = $urandom_range(0, 9);
            kind = (kind < 7) ? 0 : (kind < 8 ? 1 : 2);
            send_polygon($urandom_range(1, 6), kind);
        end
        vtx_valid = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);

        $display("%0d polygons (%0d vertices) sent, %0d clipped vertices checked",
                 polygons, sent, results_seen);
        $display("covered plane crossings, rejection, behind, overflow and long stalls");
        if (fails == 0) begin
            $display("view_pyramid_polygon_clipper_tb passed");
        end
        else begin
            $display("view_pyramid_polygon_clipper_tb failed");
        end
        $finish;
    end

endmodule
